[rtl/contiguous_block_bitmap_allocator_top_assert.svh]
// Assertion macros shared by the checker.
`ifndef CONTIGUOUS_BLOCK_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define CONTIGUOUS_BLOCK_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// antecedent in this cycle, consequent in the next one
`define CBBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cbba assertion failed");

// antecedent and consequent in the same cycle
`define CBBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cbba assertion failed");

`endif

[rtl/cbba_pkg.sv]
`default_nettype none
package cbba_pkg;

    localparam logic [1:0] OP_FIND      = 2'd0;
    localparam logic [1:0] OP_MARK_USED = 2'd1;
    localparam logic [1:0] OP_MARK_FREE = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] block_index;
        logic [8:0] run_length;
    } t_in;

    typedef struct packed {
        logic       found;
        logic [7:0] start_block;
    } t_out;

    // shared control of the bitmap ring
    typedef struct packed {
        logic shift;
        logic wr_val;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

[rtl/contiguous_block_bitmap_allocator_top.sv]
`default_nettype none
// First-fit contiguous block allocator. The free-space bitmap lives in a ring of
// NUM_BLOCKS one-bit cells; after reset blocks 0 and 1 are used and all others
// free. One request is handled at a time. A find request (opcode 0) rotates the
// ring one full turn, one bit per cycle past cell 0, counting free runs from
// FIRST_DATA_BLOCK upward, and returns the start of the first run of
// run_length free blocks (found 1) or found 0 / start 0 if none fits or the
// length is zero. Mark-used (1) and mark-free (2) write one cell directly and
// echo block_index; an index beyond the map gives found 0. Opcode 3 returns
// found 0, start 0. Results sit in an output register, so a result may wait
// on a stalled consumer while the next request goes in. start_block carries
// the low 8 bits of the run start.
module contiguous_block_bitmap_allocator_top #(
    parameter int NUM_BLOCKS       = 256,
    parameter int FIRST_DATA_BLOCK = 2
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  cbba_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    output cbba_pkg::t_out  o_out_data
);
    import cbba_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int SW    = IDX_W + 1;                     // run start, may reach NUM_BLOCKS
    localparam int CW    = (IDX_W + 1 > 9) ? IDX_W + 1 : 9; // run count vs. 9-bit length

    // fsm and datapath registers
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_step,  n_step;     // block number sitting in cell 0
    logic [CW-1:0]    r_cnt,   n_cnt;      // current free run length
    logic [SW-1:0]    r_start, n_start;    // start of current free run
    logic [8:0]       r_len,   n_len;      // requested length
    t_out             r_res,   n_res;      // pending result
    logic             r_out_valid, n_out_valid;
    t_out             r_out,   n_out;

    // fsm outputs
    logic      w_accept;
    logic      w_out_free;
    logic      w_out_load;
    t_cell_ctl w_ctl;

    // request decode
    logic                 w_is_mark;
    logic [IDX_W+7:0]     w_idx_ext;
    logic                 w_idx_ok;

    // ring taps
    logic [NUM_BLOCKS-1:0] w_used;
    logic [NUM_BLOCKS-1:0] w_we;

    // scan helpers
    logic [IDX_W+4:0] w_step_ext;
    logic             w_in_data_area;
    logic [CW-1:0]    w_cnt_inc;
    logic [SW+7:0]    w_start_ext;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_is_mark = i_in_data.opcode inside {OP_MARK_USED, OP_MARK_FREE};
    assign w_idx_ext = {{IDX_W{1'b0}}, i_in_data.block_index};
    assign w_idx_ok  = w_idx_ext < (IDX_W + 8)'(NUM_BLOCKS);

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.opcode == OP_FIND && i_in_data.run_length != 9'd0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_step == IDX_W'(NUM_BLOCKS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // fsm outputs
    // ---------------------------------------------------------------
    always_comb begin
        o_in_stall   = 1'b1;
        w_ctl.shift  = 1'b0;
        w_ctl.wr_val = (i_in_data.opcode == OP_MARK_USED);
        w_out_load   = 1'b0;
        case (r_state)
            S_IDLE:  o_in_stall  = 1'b0;
            S_SCAN:  w_ctl.shift = 1'b1;
            S_DONE:  w_out_load  = w_out_free;
            default: o_in_stall  = 1'b1;
        endcase
    end

    // ---------------------------------------------------------------
    // bitmap ring: cell k takes cell k+1 on each scan cycle, so cell 0
    // shows block r_step; after a full turn the ring is back in place
    // ---------------------------------------------------------------
    for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
        assign w_we[k] = w_accept && w_is_mark && w_idx_ok &&
                         (w_idx_ext[IDX_W-1:0] == IDX_W'(k));

        cbba_cell #(
            .RESET_USED (k < 2)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_we       (w_we[k]),
            .i_neighbor (w_used[(k + 1) % NUM_BLOCKS]),
            .o_used     (w_used[k])
        );
    end

    // ---------------------------------------------------------------
    // run counter
    // ---------------------------------------------------------------
    assign w_step_ext     = {5'd0, r_step};
    assign w_in_data_area = w_step_ext >= (IDX_W + 5)'(FIRST_DATA_BLOCK);
    assign w_cnt_inc      = r_cnt + CW'(1);
    assign w_start_ext    = {8'd0, r_start};

    always_comb begin
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_start = r_start;
        n_len   = r_len;
        n_res   = r_res;

        if (w_accept) begin
            n_step  = '0;
            n_cnt   = '0;
            n_start = SW'(FIRST_DATA_BLOCK);
            n_len   = i_in_data.run_length;
            n_res   = '0;
            if (w_is_mark) begin
                n_res.start_block = i_in_data.block_index;
                n_res.found       = w_idx_ok;
            end
        end else if (w_ctl.shift) begin
            n_step = r_step + IDX_W'(1);
            // first hit wins; keep rotating to bring the ring home
            if (w_in_data_area && !r_res.found) begin
                if (!w_used[0]) begin
                    n_cnt = w_cnt_inc;
                    if (w_cnt_inc == CW'(r_len)) begin
                        n_res.found       = 1'b1;
                        n_res.start_block = w_start_ext[7:0];
                    end
                end else begin
                    n_cnt   = '0;
                    n_start = {1'b0, r_step} + SW'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_out_load) begin
            n_out_valid = 1'b1;
            n_out       = r_res;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_cnt   <= n_cnt;
        r_start <= n_start;
        r_len   <= n_len;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

[rtl/cbba_cell.sv]
`default_nettype none
module cbba_cell #(
    parameter bit RESET_USED = 1'b0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  cbba_pkg::t_cell_ctl  i_ctl,
    input  wire                  i_we,
    input  wire                  i_neighbor,
    output logic                 o_used
);
    import cbba_pkg::*;

    logic r_used;
    logic n_used;

    // rotation wins; writes only come while the ring is at rest
    always_comb begin
        n_used = r_used;
        if (i_ctl.shift) begin
            n_used = i_neighbor;
        end else if (i_we) begin
            n_used = i_ctl.wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= RESET_USED;
        end else begin
            r_used <= n_used;
        end
    end

    assign o_used = r_used;

endmodule
`default_nettype wire

[rtl/cbba_checker.sv]
`default_nettype none
`include "contiguous_block_bitmap_allocator_top_assert.svh"
module cbba_checker (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_in_valid,
    input wire             i_in_stall,
    input cbba_pkg::t_in   i_in_data,
    input wire             i_out_valid,
    input wire             i_out_stall,
    input cbba_pkg::t_out  i_out_data
);
    import cbba_pkg::*;

    logic w_in_take;
    logic w_out_wait;
    logic w_idle_drain;

    assign w_in_take    = i_in_valid && !i_in_stall;
    assign w_out_wait   = i_out_valid && i_out_stall;
    assign w_idle_drain = !i_in_stall && i_out_valid && !i_out_stall;

    // a waiting result stays put
    `CBBA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_wait, i_out_valid)
    `CBBA_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_out_wait, $stable(i_out_data))
    // one request in flight: the block stops taking after an accept
    `CBBA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_take, i_in_stall)
    // nothing in flight: a drained result is not followed by another
    `CBBA_ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, w_idle_drain, !i_out_valid)
    // a result never appears in the cycle right after reset
    `CBBA_ASSERT_SAME(a_reset_quiet, i_clk, i_rst_n, $rose(i_rst_n), !i_out_valid)

endmodule

bind contiguous_block_bitmap_allocator_top cbba_checker u_cbba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import cbba_pkg::*;

    localparam int NUM_BLOCKS       = 256;
    localparam int FIRST_DATA_BLOCK = 2;
    // opcode with no function; the block answers found 0, start 0
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // one find turns the whole ring once, plus a little slack
    localparam int DRAIN_CYCLES     = NUM_BLOCKS + 50;
    localparam int LONG_HOLD_CYCLES = 400;

    // Tracks the free-space bitmap as the block should see it and keeps the
    // queue of grants still owed by the block, oldest first.
    class alloc_tracker;
        bit [NUM_BLOCKS-1:0] used_map;
        t_out                grant_q[$];
        int unsigned         errors;

        function new();
            used_map    = '0;
            used_map[0] = 1'b1;
            used_map[1] = 1'b1;
            errors      = 0;
        endfunction

        // first run of `want` free blocks, scanning up from the first data block
        function t_out first_fit(logic [8:0] want);
            t_out res;
            int   run;
            int   start;
            res   = '0;
            run   = 0;
            start = FIRST_DATA_BLOCK;
            if (want != 0) begin
                for (int b = FIRST_DATA_BLOCK; b < NUM_BLOCKS; b++) begin
                    if (!used_map[b]) begin
                        run++;
                    end else begin
                        run   = 0;
                        start = b + 1;
                    end
                    if (run == int'(want)) begin
                        res.found       = 1'b1;
                        res.start_block = 8'(start);
                        break;
                    end
                end
            end
            return res;
        endfunction

        // called at acceptance: update the map and queue the grant
        function t_out note_request(t_in req);
            t_out res;
            res = '0;
            case (req.opcode)
                OP_FIND: begin
                    res = first_fit(req.run_length);
                end
                OP_MARK_USED, OP_MARK_FREE: begin
                    res.start_block = req.block_index;
                    if (int'(req.block_index) < NUM_BLOCKS) begin
                        used_map[req.block_index] = (req.opcode == OP_MARK_USED);
                        res.found = 1'b1;
                    end
                end
                default: ;
            endcase
            grant_q.push_back(res);
            return res;
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (grant_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result found %0b start %0d", $time,
                         got.found, got.start_block);
                return;
            end
            want = grant_q.pop_front();
            if (got.found !== want.found) begin
                errors++;
                $display("%0t: found mismatch, expected %0b actual %0b", $time,
                         want.found, got.found);
            end
            if (got.start_block !== want.start_block) begin
                errors++;
                $display("%0t: start_block mismatch, expected %0d actual %0d", $time,
                         want.start_block, got.start_block);
            end
        endfunction
    endclass

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    logic in_valid = 1'b0;
    t_in  in_data  = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    alloc_tracker tracker;

    // idle/stall odds in percent, set per phase by the stimulus
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off: stimulus raises hold_go, receiver counts it out
    bit hold_go   = 1'b0;
    bit hold_used = 1'b0;
    int hold_left = 0;

    contiguous_block_bitmap_allocator_top #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .FIRST_DATA_BLOCK(FIRST_DATA_BLOCK)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Run limit: far beyond the slowest legal run (every request a full find,
    // worst gaps and stalls, plus the long hold-off).
    initial begin
        #80_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver. Outputs are sampled right after the edge, so the values seen
    // are the ones the block presented at that edge; out_stall is our own
    // value for that same edge.
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            tracker.check_result(out_data);
        end
        if (hold_go && !hold_used) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_used = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one request and hold it until accepted. A random gap may come
    // first. Only one assignment to in_valid per edge: either it drops for a
    // gap or it stays high with the next payload.
    task automatic issue(input logic [1:0] op, input logic [7:0] idx,
                         input logic [8:0] len, output t_out predicted);
        t_in req;
        req.opcode      = op;
        req.block_index = idx;
        req.run_length  = len;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        predicted = tracker.note_request(req);
    endtask

    // Sender pause: drop valid and wait for every owed grant.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.grant_q.size() != 0) @(posedge clk);
    endtask

    task automatic directed_checks();
        t_out g;
        issue(OP_FIND, 8'h00, 9'd0, g);        // zero length
        issue(OP_FIND, 8'hFF, 9'd1, g);
        issue(OP_FIND, 8'h00, 9'd254, g);      // whole data area
        issue(OP_FIND, 8'h00, 9'd255, g);      // one too many
        issue(OP_FIND, 8'h00, 9'd256, g);
        issue(OP_FIND, 8'hFF, 9'h1FF, g);      // longest the field allows
        issue(OP_MARK_USED, 8'hFF, 9'd0, g);   // top of the map
        issue(OP_MARK_USED, 8'd2, 9'd0, g);    // first data block
        issue(OP_FIND, 8'h00, 9'd253, g);
        issue(OP_FIND, 8'h00, 9'd252, g);
        issue(OP_MARK_FREE, 8'd0, 9'd0, g);    // reserved block, below the scan
        issue(OP_FIND, 8'h00, 9'd1, g);
        issue(OP_MARK_USED, 8'd0, 9'h1FF, g);
        issue(OP_MARK_FREE, 8'd1, 9'd0, g);
        issue(OP_MARK_USED, 8'd1, 9'd0, g);
        issue(OP_UNUSED, 8'hFF, 9'h1FF, g);
        issue(OP_UNUSED, 8'h00, 9'd0, g);
        issue(OP_MARK_USED, 8'd128, 9'd0, g);  // split the map in two
        issue(OP_FIND, 8'h00, 9'd127, g);
        issue(OP_FIND, 8'h00, 9'd128, g);
        issue(OP_FIND, 8'h00, 9'd126, g);
        issue(OP_MARK_FREE, 8'd128, 9'd0, g);
        issue(OP_MARK_FREE, 8'hFF, 9'd0, g);
        issue(OP_MARK_FREE, 8'd2, 9'd0, g);
        issue(OP_FIND, 8'h00, 9'd254, g);
    endtask

    // Mostly file-like traffic: find a run and claim it, or release a
    // stretch of blocks; the rest is single marks and raw noise.
    task automatic random_phase(input int n_items);
        t_out g;
        int   sent;
        int   pick;
        int   len;
        int   base;
        int   cnt;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                case ($urandom_range(19))
                    0:       len = 0;
                    1:       len = $urandom_range(257, 511);
                    2, 3:    len = $urandom_range(13, 256);
                    default: len = $urandom_range(1, 12);
                endcase
                issue(OP_FIND, 8'($urandom), 9'(len), g);
                sent++;
                if (g.found) begin
                    base = g.start_block;
                    cnt  = (len > 24) ? 24 : len;
                    for (int k = 0; k < cnt; k++) begin
                        issue(OP_MARK_USED, 8'(base + k), 9'($urandom), g);
                        sent++;
                    end
                end
            end else if (pick < 75) begin
                base = $urandom_range(FIRST_DATA_BLOCK, NUM_BLOCKS - 1);
                cnt  = $urandom_range(1, 16);
                for (int k = 0; k < cnt && base + k < NUM_BLOCKS; k++) begin
                    issue(OP_MARK_FREE, 8'(base + k), 9'($urandom), g);
                    sent++;
                end
            end else if (pick < 90) begin
                issue(2'($urandom_range(1, 2)), 8'($urandom), 9'($urandom), g);
                sent++;
            end else begin
                issue(2'($urandom_range(0, 3)), 8'($urandom), 9'($urandom), g);
                sent++;
            end
        end
    endtask

    initial begin
        t_out g;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();

        // back to back, no gaps on either side
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_phase(450);

        // receiver holds off for a long stretch while marks keep coming,
        // so the output register fills and the input stalls
        hold_go = 1'b1;
        repeat (12) begin
            issue(2'($urandom_range(1, 2)), 8'($urandom), 9'($urandom), g);
        end
        drain();

        send_idle_pct  = 70;
        recv_stall_pct = 0;
        random_phase(450);

        send_idle_pct  = 0;
        recv_stall_pct = 70;
        random_phase(450);
        drain();

        send_idle_pct  = 21;
        recv_stall_pct = 21;
        random_phase(450);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.grant_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
